@@ design/fmsp_pkg.sv @@
// Shared types, codes and helpers for the FLAC metadata stream parser.
// No dependencies; used by fmsp_step and flac_metadata_stream_parser_core.
package fmsp_pkg;

   // Parse phase codes
   localparam logic [4:0] PH_MAGIC  = 5'd0;
   localparam logic [4:0] PH_HDR    = 5'd1;
   localparam logic [4:0] PH_VLEN   = 5'd2;
   localparam logic [4:0] PH_VENDOR = 5'd3;
   localparam logic [4:0] PH_COUNT  = 5'd4;
   localparam logic [4:0] PH_CLEN   = 5'd5;
   localparam logic [4:0] PH_CBODY  = 5'd6;
   localparam logic [4:0] PH_PTYPE  = 5'd7;
   localparam logic [4:0] PH_MLEN   = 5'd8;
   localparam logic [4:0] PH_MIME   = 5'd9;
   localparam logic [4:0] PH_DLEN   = 5'd10;
   localparam logic [4:0] PH_DESC   = 5'd11;
   localparam logic [4:0] PH_DIMS   = 5'd12;
   localparam logic [4:0] PH_PLEN   = 5'd13;
   localparam logic [4:0] PH_PDATA  = 5'd14;
   localparam logic [4:0] PH_SKIP   = 5'd15;
   localparam logic [4:0] PH_AFTER  = 5'd16;
   localparam logic [4:0] PH_ERROR  = 5'd17;

   // Byte role codes
   localparam logic [4:0] ROLE_MAGIC       = 5'd0;
   localparam logic [4:0] ROLE_HEADER      = 5'd1;
   localparam logic [4:0] ROLE_SKIPPED     = 5'd2;
   localparam logic [4:0] ROLE_VENDOR_LEN  = 5'd3;
   localparam logic [4:0] ROLE_VENDOR      = 5'd4;
   localparam logic [4:0] ROLE_COUNT       = 5'd5;
   localparam logic [4:0] ROLE_COMMENT_LEN = 5'd6;
   localparam logic [4:0] ROLE_KEY         = 5'd7;
   localparam logic [4:0] ROLE_EQUALS      = 5'd8;
   localparam logic [4:0] ROLE_VALUE       = 5'd9;
   localparam logic [4:0] ROLE_PIC_TYPE    = 5'd10;
   localparam logic [4:0] ROLE_MIME_LEN    = 5'd11;
   localparam logic [4:0] ROLE_MIME_PREFIX = 5'd12;
   localparam logic [4:0] ROLE_MIME        = 5'd13;
   localparam logic [4:0] ROLE_DESC_LEN    = 5'd14;
   localparam logic [4:0] ROLE_DESC        = 5'd15;
   localparam logic [4:0] ROLE_DIMS        = 5'd16;
   localparam logic [4:0] ROLE_DATA_LEN    = 5'd17;
   localparam logic [4:0] ROLE_PIC_DATA    = 5'd18;
   localparam logic [4:0] ROLE_AFTER       = 5'd19;
   localparam logic [4:0] ROLE_ERROR       = 5'd20;

   // Block types and fixed byte values
   localparam logic [6:0] TYPE_COMMENT = 7'd4;
   localparam logic [6:0] TYPE_PICTURE = 7'd6;
   localparam logic [7:0] MAGIC_0      = 8'h66;
   localparam logic [7:0] MAGIC_1      = 8'h4C;
   localparam logic [7:0] MAGIC_2      = 8'h61;
   localparam logic [7:0] MAGIC_3      = 8'h43;
   localparam logic [7:0] CHAR_EQUALS  = 8'h3D;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [7:0] CASE_OFFSET  = 8'h20;
   localparam logic [31:0] DIMS_BYTES   = 32'd16;
   localparam logic [2:0]  PREFIX_BYTES = 3'd6;

   // Parser state carried from word to word
   typedef struct packed {
      logic [4:0]  phase;
      logic [1:0]  magic_index;
      logic [23:0] block_remaining;
      logic [31:0] field_remaining;
      logic [31:0] number_accum;
      logic [6:0]  current_type;
      logic        last_flag;
      logic        seen_equals;
      logic [2:0]  prefix_left;
   } state_type;

   // Tagged result word
   typedef struct packed {
      logic [4:0]  role;
      logic [7:0]  out_byte;
      logic [6:0]  block_type;
      logic        last_block;
      logic        field_done;
      logic [31:0] field_number;
      logic        block_done;
   } result_type;

   localparam state_type STATE_RESET = '{
      phase: PH_MAGIC, magic_index: 2'd0, block_remaining: 24'd0,
      field_remaining: 32'd0, number_accum: 32'd0, current_type: 7'd0,
      last_flag: 1'b0, seen_equals: 1'b0, prefix_left: 3'd0
   };

   // Clip a string length to the room left in the block
   function automatic logic [31:0] clip_len(input logic [31:0] len,
                                            input logic [23:0] room);
      logic [31:0] room_w;
      room_w = {8'd0, room};
      return (len > room_w) ? room_w : len;
   endfunction

   // Expected magic byte at a given position
   function automatic logic [7:0] magic_byte(input logic [1:0] idx);
      logic [7:0] m;
      case (idx)
         2'd0:    m = MAGIC_0;
         2'd1:    m = MAGIC_1;
         2'd2:    m = MAGIC_2;
         default: m = MAGIC_3;
      endcase
      return m;
   endfunction

endpackage

@@ design/fmsp_step.sv @@
// Per-word tagging logic: next parser state and the result for one byte.
// Purely combinational; depends on fmsp_pkg.
module fmsp_step (
   input  fmsp_pkg::state_type  state_ff,
   input  logic [7:0]           data_byte,
   input  logic                 stream_start,
   output fmsp_pkg::state_type  state_in,
   output fmsp_pkg::result_type result
);

   always_comb begin
      fmsp_pkg::state_type s;
      logic [7:0]  b;
      logic [4:0]  role;
      logic [7:0]  obyte;
      logic        fdone;
      logic [31:0] fnum;
      logic        bdone;
      logic [23:0] room;
      logic [31:0] num_next;
      logic        num_done;
      logic [31:0] len;
      logic [31:0] flen;
      logic        is_string;
      logic        is_number;
      logic        big_endian;

      // restart on stream start
      s = stream_start ? fmsp_pkg::STATE_RESET : state_ff;
      b = data_byte;
      role = fmsp_pkg::ROLE_SKIPPED;
      obyte = b;
      fdone = 1'b0;
      fnum = 32'd0;
      bdone = 1'b0;
      room = s.block_remaining - 24'd1;
      len = 32'd0;
      flen = 32'd0;

      // assemble one byte of a 4-byte number
      big_endian = (s.phase == fmsp_pkg::PH_PTYPE) || (s.phase == fmsp_pkg::PH_MLEN) ||
                   (s.phase == fmsp_pkg::PH_DLEN) || (s.phase == fmsp_pkg::PH_PLEN);
      if (big_endian) begin
         num_next = {s.number_accum[23:0], b};
      end else begin
         num_next = s.number_accum | ({24'd0, b} << {s.magic_index, 3'b000});
      end
      num_done = (s.magic_index == 2'd3);
      is_number = 1'b0;
      is_string = 1'b0;

      case (s.phase)
         fmsp_pkg::PH_MAGIC: begin
            if (b == fmsp_pkg::magic_byte(s.magic_index)) begin
               role = fmsp_pkg::ROLE_MAGIC;
               if (s.magic_index == 2'd3) begin
                  s.magic_index = 2'd0;
                  s.number_accum = 32'd0;
                  s.phase = fmsp_pkg::PH_HDR;
               end else begin
                  s.magic_index = s.magic_index + 2'd1;
               end
            end else begin
               role = fmsp_pkg::ROLE_ERROR;
               s.phase = fmsp_pkg::PH_ERROR;
            end
         end
         fmsp_pkg::PH_ERROR: role = fmsp_pkg::ROLE_ERROR;
         fmsp_pkg::PH_AFTER: role = fmsp_pkg::ROLE_AFTER;
         fmsp_pkg::PH_HDR: begin
            role = fmsp_pkg::ROLE_HEADER;
            if (s.magic_index == 2'd0) begin
               s.last_flag = b[7];
               s.current_type = b[6:0];
               s.number_accum = 32'd0;
               s.magic_index = 2'd1;
            end else begin
               s.number_accum = {8'd0, s.number_accum[15:0], b};
               if (s.magic_index == 2'd3) begin
                  s.magic_index = 2'd0;
                  s.block_remaining = s.number_accum[23:0];
                  fnum = s.number_accum;
                  s.number_accum = 32'd0;
                  fdone = 1'b1;
                  if (s.block_remaining == 24'd0) begin
                     bdone = 1'b1;
                     s.phase = s.last_flag ? fmsp_pkg::PH_AFTER : fmsp_pkg::PH_HDR;
                  end else if (s.current_type == fmsp_pkg::TYPE_COMMENT) begin
                     s.phase = fmsp_pkg::PH_VLEN;
                  end else if (s.current_type == fmsp_pkg::TYPE_PICTURE) begin
                     s.phase = fmsp_pkg::PH_PTYPE;
                  end else begin
                     s.phase = fmsp_pkg::PH_SKIP;
                  end
               end else begin
                  s.magic_index = s.magic_index + 2'd1;
               end
            end
         end
         fmsp_pkg::PH_VLEN:   begin role = fmsp_pkg::ROLE_VENDOR_LEN;  is_number = 1'b1; end
         fmsp_pkg::PH_COUNT:  begin role = fmsp_pkg::ROLE_COUNT;       is_number = 1'b1; end
         fmsp_pkg::PH_CLEN:   begin role = fmsp_pkg::ROLE_COMMENT_LEN; is_number = 1'b1; end
         fmsp_pkg::PH_PTYPE:  begin role = fmsp_pkg::ROLE_PIC_TYPE;    is_number = 1'b1; end
         fmsp_pkg::PH_MLEN:   begin role = fmsp_pkg::ROLE_MIME_LEN;    is_number = 1'b1; end
         fmsp_pkg::PH_DLEN:   begin role = fmsp_pkg::ROLE_DESC_LEN;    is_number = 1'b1; end
         fmsp_pkg::PH_PLEN:   begin role = fmsp_pkg::ROLE_DATA_LEN;    is_number = 1'b1; end
         fmsp_pkg::PH_VENDOR: begin role = fmsp_pkg::ROLE_VENDOR;      is_string = 1'b1; end
         fmsp_pkg::PH_DESC:   begin role = fmsp_pkg::ROLE_DESC;        is_string = 1'b1; end
         fmsp_pkg::PH_DIMS:   begin role = fmsp_pkg::ROLE_DIMS;        is_string = 1'b1; end
         fmsp_pkg::PH_PDATA:  begin role = fmsp_pkg::ROLE_PIC_DATA;    is_string = 1'b1; end
         fmsp_pkg::PH_CBODY: begin
            is_string = 1'b1;
            if (s.seen_equals) begin
               role = fmsp_pkg::ROLE_VALUE;
            end else if (b == fmsp_pkg::CHAR_EQUALS) begin
               role = fmsp_pkg::ROLE_EQUALS;
               s.seen_equals = 1'b1;
            end else begin
               role = fmsp_pkg::ROLE_KEY;
               if (b >= fmsp_pkg::CHAR_UPPER_A && b <= fmsp_pkg::CHAR_UPPER_Z) begin
                  obyte = b + fmsp_pkg::CASE_OFFSET;
               end
            end
         end
         fmsp_pkg::PH_MIME: begin
            is_string = 1'b1;
            if (s.prefix_left != 3'd0) begin
               role = fmsp_pkg::ROLE_MIME_PREFIX;
               s.prefix_left = s.prefix_left - 3'd1;
            end else begin
               role = fmsp_pkg::ROLE_MIME;
            end
         end
         default: role = fmsp_pkg::ROLE_SKIPPED;
      endcase

      // number fields: complete, then open the following string or field
      if (is_number) begin
         if (num_done) begin
            fdone = 1'b1;
            fnum = num_next;
            s.number_accum = 32'd0;
            s.magic_index = 2'd0;
            len = fmsp_pkg::clip_len(num_next, room);
            flen = fmsp_pkg::clip_len(fmsp_pkg::DIMS_BYTES, room);
            case (s.phase)
               fmsp_pkg::PH_VLEN: begin
                  s.field_remaining = len;
                  s.phase = (len == 32'd0) ? fmsp_pkg::PH_COUNT : fmsp_pkg::PH_VENDOR;
               end
               fmsp_pkg::PH_COUNT: s.phase = fmsp_pkg::PH_CLEN;
               fmsp_pkg::PH_CLEN: begin
                  s.seen_equals = 1'b0;
                  s.field_remaining = len;
                  s.phase = (len == 32'd0) ? fmsp_pkg::PH_CLEN : fmsp_pkg::PH_CBODY;
               end
               fmsp_pkg::PH_PTYPE: s.phase = fmsp_pkg::PH_MLEN;
               fmsp_pkg::PH_MLEN: begin
                  s.field_remaining = len;
                  s.phase = (len == 32'd0) ? fmsp_pkg::PH_DLEN : fmsp_pkg::PH_MIME;
                  s.prefix_left = (len > {29'd0, fmsp_pkg::PREFIX_BYTES}) ?
                                  fmsp_pkg::PREFIX_BYTES : 3'd0;
               end
               fmsp_pkg::PH_DLEN: begin
                  if (len != 32'd0) begin
                     s.field_remaining = len;
                     s.phase = fmsp_pkg::PH_DESC;
                  end else begin
                     s.field_remaining = flen;
                     s.phase = (flen == 32'd0) ? fmsp_pkg::PH_PLEN : fmsp_pkg::PH_DIMS;
                  end
               end
               default: begin
                  s.field_remaining = len;
                  s.phase = (len == 32'd0) ? fmsp_pkg::PH_SKIP : fmsp_pkg::PH_PDATA;
               end
            endcase
         end else begin
            s.number_accum = num_next;
            s.magic_index = s.magic_index + 2'd1;
         end
      end

      // strings: count down, advance at the end
      if (is_string) begin
         s.field_remaining = s.field_remaining - 32'd1;
         if (s.field_remaining == 32'd0) begin
            fdone = 1'b1;
            flen = fmsp_pkg::clip_len(fmsp_pkg::DIMS_BYTES, room);
            case (s.phase)
               fmsp_pkg::PH_VENDOR: s.phase = fmsp_pkg::PH_COUNT;
               fmsp_pkg::PH_CBODY:  s.phase = fmsp_pkg::PH_CLEN;
               fmsp_pkg::PH_MIME:   s.phase = fmsp_pkg::PH_DLEN;
               fmsp_pkg::PH_DESC: begin
                  s.field_remaining = flen;
                  s.phase = (flen == 32'd0) ? fmsp_pkg::PH_PLEN : fmsp_pkg::PH_DIMS;
               end
               fmsp_pkg::PH_DIMS:   s.phase = fmsp_pkg::PH_PLEN;
               default:             s.phase = fmsp_pkg::PH_SKIP;
            endcase
         end
      end

      // body bytes: count the block down and drop to the next header at its end
      if (is_number || is_string ||
          ((stream_start ? fmsp_pkg::PH_MAGIC : state_ff.phase) == fmsp_pkg::PH_SKIP)) begin
         s.block_remaining = room;
         if (room == 24'd0) begin
            bdone = 1'b1;
            s.magic_index = 2'd0;
            s.number_accum = 32'd0;
            s.phase = s.last_flag ? fmsp_pkg::PH_AFTER : fmsp_pkg::PH_HDR;
         end
      end

      state_in = s;
      result.role = role;
      result.out_byte = obyte;
      result.block_type = s.current_type;
      result.last_block = s.last_flag;
      result.field_done = fdone;
      result.field_number = fnum;
      result.block_done = bdone;
   end

endmodule

@@ design/flac_metadata_stream_parser_core.sv @@
// A byte's tag reaches rsp_ from the result register, via the skid if that is full.
// Throughput: one byte per cycle while the skid is empty; the tagging logic in
// fmsp_step sits between the parser state registers and the result register, with
// a one-word skid behind it. Reset (synchronous, active high) returns the parser to
// waiting for the magic and empties the result and skid registers. req_stream_start
// restarts parsing too. Depends on fmsp_pkg and fmsp_step.
module flac_metadata_stream_parser_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_stream_start,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [4:0]  rsp_role,
   output logic [7:0]  rsp_out_byte,
   output logic [6:0]  rsp_block_type,
   output logic        rsp_last_block,
   output logic        rsp_field_done,
   output logic [31:0] rsp_field_number,
   output logic        rsp_block_done
);

   fmsp_pkg::state_type  state_ff, state_in;
   fmsp_pkg::result_type result_in, out_ff, skid_ff;
   logic                 out_valid_ff, skid_valid_ff;
   logic                 accept, take;

   fmsp_step u_step (
      .state_ff     (state_ff),
      .data_byte    (req_data_byte),
      .stream_start (req_stream_start),
      .state_in     (state_in),
      .result       (result_in)
   );

   assign req_ready = !skid_valid_ff;
   assign accept    = req_valid && req_ready;
   assign take      = out_valid_ff && rsp_ready;

   // advance parser state on each accepted word
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= fmsp_pkg::STATE_RESET;
      end else if (accept) begin
         state_ff <= state_in;
      end
   end

   // result register with a one-word skid
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (take) begin
            skid_valid_ff <= 1'b0;
         end
      end else if (accept) begin
         if (!out_valid_ff || take) begin
            out_valid_ff <= 1'b1;
         end else begin
            skid_valid_ff <= 1'b1;
         end
      end else if (take) begin
         out_valid_ff <= 1'b0;
      end
   end

   // payload moves without reset
   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (take) begin
            out_ff <= skid_ff;
         end
      end else if (accept) begin
         if (!out_valid_ff || take) begin
            out_ff <= result_in;
         end else begin
            skid_ff <= result_in;
         end
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_role         = out_ff.role;
   assign rsp_out_byte     = out_ff.out_byte;
   assign rsp_block_type   = out_ff.block_type;
   assign rsp_last_block   = out_ff.last_block;
   assign rsp_field_done   = out_ff.field_done;
   assign rsp_field_number = out_ff.field_number;
   assign rsp_block_done   = out_ff.block_done;

   // skid holds a word only behind a full result register
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid valid without result valid");

   // key bytes never carry an uppercase letter
   a_key_lower: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_role == fmsp_pkg::ROLE_KEY) |->
      (rsp_out_byte < fmsp_pkg::CHAR_UPPER_A || rsp_out_byte > fmsp_pkg::CHAR_UPPER_Z))
      else $error("uppercase byte tagged as key");

   // a nonzero number only comes with a completed field
   a_number_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_field_number != 32'd0) |-> rsp_field_done)
      else $error("field number without field done");

   // error phase holds until a stream start
   a_error_sticky: assert property (@(posedge clock) disable iff (reset)
      (accept && !req_stream_start && state_ff.phase == fmsp_pkg::PH_ERROR) |=>
      (state_ff.phase == fmsp_pkg::PH_ERROR))
      else $error("left error phase without stream start");

endmodule

@@ tb/sv/tb_flac_metadata_stream_parser_core.sv @@
`timescale 1ns / 100ps
// Self-checking bench for flac_metadata_stream_parser_core: directed and random byte streams,
// each tagged word checked against an in-bench parser model. Depends on fmsp_pkg.
module tb_flac_metadata_stream_parser_core;

   localparam int RANDOM_WORDS = 1150;
   localparam int LIMIT_CYCLES = 200000;
   localparam int STALL_CYCLES = 80;
   localparam int DRAIN_CYCLES = 10;
   localparam logic [31:0] FLAC_MAGIC = {fmsp_pkg::MAGIC_0, fmsp_pkg::MAGIC_1,
                                         fmsp_pkg::MAGIC_2, fmsp_pkg::MAGIC_3};

   // One input word, with an optional typed expectation for the directed rows
   typedef struct packed {
      logic        start;
      logic [7:0]  data;
      logic        typed;
      logic [4:0]  role;
      logic        fdone;
      logic [31:0] fnum;
      logic        bdone;
   } feed_word_type;

   logic        clock;
   logic        reset            = 1'b1;
   logic        req_valid        = 1'b0;
   logic        req_ready;
   logic [7:0]  req_data_byte    = 8'd0;
   logic        req_stream_start = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready        = 1'b0;
   logic [4:0]  rsp_role;
   logic [7:0]  rsp_out_byte;
   logic [6:0]  rsp_block_type;
   logic        rsp_last_block;
   logic        rsp_field_done;
   logic [31:0] rsp_field_number;
   logic        rsp_block_done;

   logic                 stall_hold = 1'b0;
   feed_word_type        feed_q[$];
   fmsp_pkg::result_type tag_queue[$];
   logic [7:0]           body_q[$];
   fmsp_pkg::state_type  pst = fmsp_pkg::STATE_RESET;
   logic [20:0]          role_seen = '0;
   int                   fed_count = 0;
   int                   next_idx = 0;
   int                   checked_count = 0;
   int                   err_count = 0;
   int                   stream_count = 0;
   int                   cycle_count = 0;

   // Directed words: bad magic, empty block, clipped vendor string, after-metadata, restart
   feed_word_type dir_rows [0:23] = '{
      '{1'b1, 8'h00, 1'b1, fmsp_pkg::ROLE_ERROR,      1'b0, 32'd0,        1'b0},
      '{1'b0, 8'hFF, 1'b1, fmsp_pkg::ROLE_ERROR,      1'b0, 32'd0,        1'b0},
      '{1'b1, 8'h66, 1'b1, fmsp_pkg::ROLE_MAGIC,      1'b0, 32'd0,        1'b0},
      '{1'b0, 8'h4C, 1'b1, fmsp_pkg::ROLE_MAGIC,      1'b0, 32'd0,        1'b0},
      '{1'b0, 8'h61, 1'b1, fmsp_pkg::ROLE_MAGIC,      1'b0, 32'd0,        1'b0},
      '{1'b0, 8'h43, 1'b1, fmsp_pkg::ROLE_MAGIC,      1'b0, 32'd0,        1'b0},
      '{1'b0, 8'h00, 1'b1, fmsp_pkg::ROLE_HEADER,     1'b0, 32'd0,        1'b0},
      '{1'b0, 8'h00, 1'b1, fmsp_pkg::ROLE_HEADER,     1'b0, 32'd0,        1'b0},
      '{1'b0, 8'h00, 1'b1, fmsp_pkg::ROLE_HEADER,     1'b0, 32'd0,        1'b0},
      '{1'b0, 8'h00, 1'b1, fmsp_pkg::ROLE_HEADER,     1'b1, 32'd0,        1'b1},
      '{1'b0, 8'h84, 1'b0, '0,                        1'b0, 32'd0,        1'b0},
      '{1'b0, 8'h00, 1'b0, '0,                        1'b0, 32'd0,        1'b0},
      '{1'b0, 8'h00, 1'b0, '0,                        1'b0, 32'd0,        1'b0},
      '{1'b0, 8'h05, 1'b0, '0,                        1'b0, 32'd0,        1'b0},
      '{1'b0, 8'hFF, 1'b0, '0,                        1'b0, 32'd0,        1'b0},
      '{1'b0, 8'hFF, 1'b0, '0,                        1'b0, 32'd0,        1'b0},
      '{1'b0, 8'hFF, 1'b0, '0,                        1'b0, 32'd0,        1'b0},
      '{1'b0, 8'hFF, 1'b1, fmsp_pkg::ROLE_VENDOR_LEN, 1'b1, 32'hFFFFFFFF, 1'b0},
      '{1'b0, 8'h7F, 1'b1, fmsp_pkg::ROLE_VENDOR,     1'b1, 32'd0,        1'b1},
      '{1'b0, 8'hAB, 1'b1, fmsp_pkg::ROLE_AFTER,      1'b0, 32'd0,        1'b0},
      '{1'b0, 8'h00, 1'b1, fmsp_pkg::ROLE_AFTER,      1'b0, 32'd0,        1'b0},
      '{1'b1, 8'h66, 1'b1, fmsp_pkg::ROLE_MAGIC,      1'b0, 32'd0,        1'b0},
      '{1'b0, 8'h4C, 1'b1, fmsp_pkg::ROLE_MAGIC,      1'b0, 32'd0,        1'b0},
      '{1'b0, 8'h00, 1'b1, fmsp_pkg::ROLE_ERROR,      1'b0, 32'd0,        1'b0}
   };

   flac_metadata_stream_parser_core DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_data_byte(req_data_byte), .req_stream_start(req_stream_start),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_role(rsp_role), .rsp_out_byte(rsp_out_byte),
      .rsp_block_type(rsp_block_type), .rsp_last_block(rsp_last_block),
      .rsp_field_done(rsp_field_done), .rsp_field_number(rsp_field_number),
      .rsp_block_done(rsp_block_done)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // ---------------- parser model ----------------

   // Add one byte to a 4-byte number; return 1 once the fourth byte is in
   function automatic logic take_number(input logic [7:0] b, input logic big,
                                        output logic [31:0] val);
      if (big)
         pst.number_accum = {pst.number_accum[23:0], b};
      else
         pst.number_accum = pst.number_accum | ({24'd0, b} << (8 * pst.magic_index));
      val = pst.number_accum;
      if (pst.magic_index == 2'd3) begin
         pst.number_accum = 32'd0;
         pst.magic_index = 2'd0;
         return 1'b1;
      end
      pst.magic_index = pst.magic_index + 2'd1;
      return 1'b0;
   endfunction

   // Open a string clipped to the room left; pass over it when empty
   function automatic void open_string(input logic [31:0] len, input logic [23:0] room,
                                       input logic [4:0] ph, input logic [4:0] skip_ph);
      logic [31:0] n;
      n = (len > {8'd0, room}) ? {8'd0, room} : len;
      pst.field_remaining = n;
      pst.phase = (n == 32'd0) ? skip_ph : ph;
   endfunction

   // Tag one byte and advance the model state
   function automatic fmsp_pkg::result_type tag_byte(input logic [7:0] b, input logic start);
      fmsp_pkg::result_type r;
      logic [23:0]          room;
      logic [31:0]          v;
      r = '0;
      r.role = fmsp_pkg::ROLE_SKIPPED;
      r.out_byte = b;
      if (start)
         pst = fmsp_pkg::STATE_RESET;
      case (pst.phase)
         fmsp_pkg::PH_MAGIC: begin
            if (b == FLAC_MAGIC[8 * (3 - pst.magic_index) +: 8]) begin
               r.role = fmsp_pkg::ROLE_MAGIC;
               if (pst.magic_index == 2'd3) begin
                  pst.magic_index = 2'd0;
                  pst.number_accum = 32'd0;
                  pst.phase = fmsp_pkg::PH_HDR;
               end else begin
                  pst.magic_index = pst.magic_index + 2'd1;
               end
            end else begin
               r.role = fmsp_pkg::ROLE_ERROR;
               pst.phase = fmsp_pkg::PH_ERROR;
            end
         end
         fmsp_pkg::PH_ERROR: r.role = fmsp_pkg::ROLE_ERROR;
         fmsp_pkg::PH_AFTER: r.role = fmsp_pkg::ROLE_AFTER;
         fmsp_pkg::PH_HDR: begin
            r.role = fmsp_pkg::ROLE_HEADER;
            if (pst.magic_index == 2'd0) begin
               pst.last_flag = b[7];
               pst.current_type = b[6:0];
               pst.number_accum = 32'd0;
               pst.magic_index = 2'd1;
            end else begin
               pst.number_accum = {8'd0, pst.number_accum[15:0], b};
               if (pst.magic_index == 2'd3) begin
                  pst.magic_index = 2'd0;
                  pst.block_remaining = pst.number_accum[23:0];
                  r.field_number = pst.number_accum;
                  r.field_done = 1'b1;
                  pst.number_accum = 32'd0;
                  if (pst.block_remaining == 24'd0) begin
                     r.block_done = 1'b1;
                     pst.phase = pst.last_flag ? fmsp_pkg::PH_AFTER : fmsp_pkg::PH_HDR;
                  end else if (pst.current_type == fmsp_pkg::TYPE_COMMENT) begin
                     pst.phase = fmsp_pkg::PH_VLEN;
                  end else if (pst.current_type == fmsp_pkg::TYPE_PICTURE) begin
                     pst.phase = fmsp_pkg::PH_PTYPE;
                  end else begin
                     pst.phase = fmsp_pkg::PH_SKIP;
                  end
               end else begin
                  pst.magic_index = pst.magic_index + 2'd1;
               end
            end
         end
         default: begin
            // body byte of a block
            room = pst.block_remaining - 24'd1;
            case (pst.phase)
               fmsp_pkg::PH_VLEN: begin
                  r.role = fmsp_pkg::ROLE_VENDOR_LEN;
                  if (take_number(b, 1'b0, v)) begin
                     r.field_done = 1'b1;
                     r.field_number = v;
                     open_string(v, room, fmsp_pkg::PH_VENDOR, fmsp_pkg::PH_COUNT);
                  end
               end
               fmsp_pkg::PH_COUNT: begin
                  r.role = fmsp_pkg::ROLE_COUNT;
                  if (take_number(b, 1'b0, v)) begin
                     r.field_done = 1'b1;
                     r.field_number = v;
                     pst.phase = fmsp_pkg::PH_CLEN;
                  end
               end
               fmsp_pkg::PH_CLEN: begin
                  r.role = fmsp_pkg::ROLE_COMMENT_LEN;
                  if (take_number(b, 1'b0, v)) begin
                     r.field_done = 1'b1;
                     r.field_number = v;
                     pst.seen_equals = 1'b0;
                     open_string(v, room, fmsp_pkg::PH_CBODY, fmsp_pkg::PH_CLEN);
                  end
               end
               fmsp_pkg::PH_PTYPE: begin
                  r.role = fmsp_pkg::ROLE_PIC_TYPE;
                  if (take_number(b, 1'b1, v)) begin
                     r.field_done = 1'b1;
                     r.field_number = v;
                     pst.phase = fmsp_pkg::PH_MLEN;
                  end
               end
               fmsp_pkg::PH_MLEN: begin
                  r.role = fmsp_pkg::ROLE_MIME_LEN;
                  if (take_number(b, 1'b1, v)) begin
                     r.field_done = 1'b1;
                     r.field_number = v;
                     open_string(v, room, fmsp_pkg::PH_MIME, fmsp_pkg::PH_DLEN);
                     pst.prefix_left = (pst.field_remaining > 32'd6) ?
                                       fmsp_pkg::PREFIX_BYTES : 3'd0;
                  end
               end
               fmsp_pkg::PH_DLEN: begin
                  r.role = fmsp_pkg::ROLE_DESC_LEN;
                  if (take_number(b, 1'b1, v)) begin
                     r.field_done = 1'b1;
                     r.field_number = v;
                     open_string(v, room, fmsp_pkg::PH_DESC, fmsp_pkg::PH_DIMS);
                     if (pst.phase == fmsp_pkg::PH_DIMS)
                        open_string(fmsp_pkg::DIMS_BYTES, room, fmsp_pkg::PH_DIMS,
                                    fmsp_pkg::PH_PLEN);
                  end
               end
               fmsp_pkg::PH_PLEN: begin
                  r.role = fmsp_pkg::ROLE_DATA_LEN;
                  if (take_number(b, 1'b1, v)) begin
                     r.field_done = 1'b1;
                     r.field_number = v;
                     open_string(v, room, fmsp_pkg::PH_PDATA, fmsp_pkg::PH_SKIP);
                  end
               end
               fmsp_pkg::PH_VENDOR, fmsp_pkg::PH_CBODY, fmsp_pkg::PH_MIME,
               fmsp_pkg::PH_DESC, fmsp_pkg::PH_DIMS, fmsp_pkg::PH_PDATA: begin
                  // tag a string byte, then close the string on its last byte
                  case (pst.phase)
                     fmsp_pkg::PH_VENDOR: r.role = fmsp_pkg::ROLE_VENDOR;
                     fmsp_pkg::PH_CBODY: begin
                        if (pst.seen_equals) begin
                           r.role = fmsp_pkg::ROLE_VALUE;
                        end else if (b == fmsp_pkg::CHAR_EQUALS) begin
                           r.role = fmsp_pkg::ROLE_EQUALS;
                           pst.seen_equals = 1'b1;
                        end else begin
                           r.role = fmsp_pkg::ROLE_KEY;
                           if (b >= fmsp_pkg::CHAR_UPPER_A && b <= fmsp_pkg::CHAR_UPPER_Z)
                              r.out_byte = b + fmsp_pkg::CASE_OFFSET;
                        end
                     end
                     fmsp_pkg::PH_MIME: begin
                        if (pst.prefix_left != 3'd0) begin
                           r.role = fmsp_pkg::ROLE_MIME_PREFIX;
                           pst.prefix_left = pst.prefix_left - 3'd1;
                        end else begin
                           r.role = fmsp_pkg::ROLE_MIME;
                        end
                     end
                     fmsp_pkg::PH_DESC: r.role = fmsp_pkg::ROLE_DESC;
                     fmsp_pkg::PH_DIMS: r.role = fmsp_pkg::ROLE_DIMS;
                     default:           r.role = fmsp_pkg::ROLE_PIC_DATA;
                  endcase
                  pst.field_remaining = pst.field_remaining - 32'd1;
                  if (pst.field_remaining == 32'd0) begin
                     r.field_done = 1'b1;
                     case (pst.phase)
                        fmsp_pkg::PH_VENDOR: pst.phase = fmsp_pkg::PH_COUNT;
                        fmsp_pkg::PH_CBODY:  pst.phase = fmsp_pkg::PH_CLEN;
                        fmsp_pkg::PH_MIME:   pst.phase = fmsp_pkg::PH_DLEN;
                        fmsp_pkg::PH_DESC:   open_string(fmsp_pkg::DIMS_BYTES, room,
                                                         fmsp_pkg::PH_DIMS, fmsp_pkg::PH_PLEN);
                        fmsp_pkg::PH_DIMS:   pst.phase = fmsp_pkg::PH_PLEN;
                        default:             pst.phase = fmsp_pkg::PH_SKIP;
                     endcase
                  end
               end
               default: r.role = fmsp_pkg::ROLE_SKIPPED;
            endcase
            pst.block_remaining = room;
            if (room == 24'd0) begin
               r.block_done = 1'b1;
               pst.magic_index = 2'd0;
               pst.number_accum = 32'd0;
               pst.phase = pst.last_flag ? fmsp_pkg::PH_AFTER : fmsp_pkg::PH_HDR;
            end
         end
      endcase
      r.block_type = pst.current_type;
      r.last_block = pst.last_flag;
      return r;
   endfunction

   // ---------------- stream generation ----------------

   task automatic put_word(input logic [7:0] b, input logic start);
      feed_word_type w;
      w = '0;
      w.start = start;
      w.data = b;
      feed_q.push_back(w);
   endtask

   task automatic body_le32(input logic [31:0] v);
      for (int i = 0; i < 4; i++)
         body_q.push_back(v[8 * i +: 8]);
   endtask

   task automatic body_be32(input logic [31:0] v);
      for (int i = 3; i >= 0; i--)
         body_q.push_back(v[8 * i +: 8]);
   endtask

   task automatic body_rand(input int n);
      repeat (n) body_q.push_back(8'($urandom_range(255)));
   endtask

   // Mostly the true length; sometimes a wild or a small one
   function automatic logic [31:0] skew_len(input int n);
      int r;
      r = $urandom_range(99);
      if (r < 8)
         return $urandom;
      if (r < 14)
         return $urandom_range(12);
      return n;
   endfunction

   function automatic logic [7:0] key_char();
      case ($urandom_range(3))
         0:       return 8'($urandom_range(fmsp_pkg::CHAR_UPPER_A, fmsp_pkg::CHAR_UPPER_Z));
         1:       return 8'($urandom_range(8'h61, 8'h7A));
         2:       return 8'($urandom_range(255));
         default: return ($urandom_range(1)) ? fmsp_pkg::CHAR_UPPER_A - 8'd1 :
                                               fmsp_pkg::CHAR_UPPER_Z + 8'd1;
      endcase
   endfunction

   task automatic build_comment_body();
      int  n;
      int  ncom;
      int  klen;
      int  vlen;
      int  has_eq;
      n = $urandom_range(6);
      body_le32(skew_len(n));
      body_rand(n);
      ncom = $urandom_range(3);
      body_le32(($urandom_range(9) == 0) ? $urandom : ncom);
      repeat (ncom) begin
         klen = $urandom_range(1, 5);
         vlen = $urandom_range(5);
         has_eq = ($urandom_range(4) != 0);
         body_le32(skew_len(klen + has_eq + vlen));
         repeat (klen) body_q.push_back(key_char());
         if (has_eq)
            body_q.push_back(fmsp_pkg::CHAR_EQUALS);
         body_rand(vlen);
      end
   endtask

   task automatic build_picture_body();
      int n;
      body_be32(($urandom_range(3) == 0) ? $urandom : $urandom_range(20));
      n = $urandom_range(12);
      body_be32(skew_len(n));
      body_rand(n);
      n = $urandom_range(6);
      body_be32(skew_len(n));
      body_rand(n);
      body_rand(16);
      n = $urandom_range(10);
      body_be32(skew_len(n));
      body_rand(n);
      if ($urandom_range(1))
         body_rand($urandom_range(1, 3));
   endtask

   // Append one file: noise, a broken magic, or a chain of blocks
   task automatic build_stream();
      int          kind;
      int          nblk;
      int          k;
      int          r;
      logic [23:0] len;
      logic        is_last;
      logic [6:0]  btype;
      stream_count++;
      kind = $urandom_range(99);
      if (kind < 10) begin
         put_word(8'($urandom_range(255)), 1'b1);
         repeat ($urandom_range(6)) put_word(8'($urandom_range(255)), 1'b0);
         return;
      end
      if (kind < 20) begin
         k = $urandom_range(3);
         for (int i = 0; i < k; i++)
            put_word(FLAC_MAGIC[8 * (3 - i) +: 8], i == 0);
         put_word(FLAC_MAGIC[8 * (3 - k) +: 8] ^ (8'd1 << $urandom_range(7)), k == 0);
         repeat ($urandom_range(4)) put_word(8'($urandom_range(255)), 1'b0);
         return;
      end
      for (int i = 0; i < 4; i++)
         put_word(FLAC_MAGIC[8 * (3 - i) +: 8], i == 0);
      nblk = $urandom_range(1, 3);
      for (int blk = 0; blk < nblk; blk++) begin
         body_q.delete();
         r = $urandom_range(99);
         if (r < 40) begin
            btype = fmsp_pkg::TYPE_COMMENT;
            build_comment_body();
         end else if (r < 75) begin
            btype = fmsp_pkg::TYPE_PICTURE;
            build_picture_body();
         end else begin
            btype = 7'($urandom_range(127));
            body_rand($urandom_range(10));
         end
         is_last = (blk == nblk - 1) && ($urandom_range(6) != 0);
         len = 24'(body_q.size());
         r = $urandom_range(99);
         if (r < 5)
            len = 24'($urandom);
         else if (r < 20)
            len = 24'($urandom_range(body_q.size() + 4));
         put_word({is_last, btype}, 1'b0);
         put_word(len[23:16], 1'b0);
         put_word(len[15:8], 1'b0);
         put_word(len[7:0], 1'b0);
         // abandon a huge block after its built body; the next file restarts parsing
         if (r < 5) begin
            foreach (body_q[i]) put_word(body_q[i], 1'b0);
            return;
         end
         for (int i = 0; i < len; i++)
            put_word((i < body_q.size()) ? body_q[i] : 8'($urandom_range(255)), 1'b0);
         if (is_last) begin
            repeat ($urandom_range(4)) put_word(8'($urandom_range(255)), 1'b0);
            return;
         end
      end
   endtask

   // ---------------- checking ----------------

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      err_count++;
      $display("MISMATCH t=%0t word %0d: %s got %0h want %0h",
               $time, checked_count, what, got, want);
   endtask

   task automatic check_field(input string what, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want)
         report_mismatch(what, got, want);
   endtask

   // Drive both channels, predict accepted words and check returned tags
   always @(posedge clock) begin : bus_side
      fmsp_pkg::result_type want;
      feed_word_type        row;
      int                   third;
      int                   send_pct;
      int                   recv_pct;
      third = feed_q.size() / 3;
      if (fed_count < third) begin
         send_pct = 20;
         recv_pct = 69;
      end else if (fed_count < 2 * third) begin
         send_pct = 69;
         recv_pct = 20;
      end else begin
         send_pct = 0;
         recv_pct = 0;
      end
      if (reset) begin
         req_valid <= 1'b0;
         rsp_ready <= 1'b0;
      end else begin
         // predict the word taken at this edge
         if (req_valid && req_ready) begin
            row = feed_q[fed_count];
            want = tag_byte(req_data_byte, req_stream_start);
            if (row.typed) begin
               want.role = row.role;
               want.field_done = row.fdone;
               want.field_number = row.fnum;
               want.block_done = row.bdone;
            end
            tag_queue.push_back(want);
            fed_count++;
         end
         // compare the tag taken at this edge with the oldest prediction
         if (rsp_valid && rsp_ready) begin
            if (tag_queue.size() == 0) begin
               report_mismatch("tag with nothing expected, role", 32'(rsp_role), 32'd0);
            end else begin
               want = tag_queue.pop_front();
               role_seen[want.role] = 1'b1;
               check_field("role", 32'(rsp_role), 32'(want.role));
               check_field("out_byte", 32'(rsp_out_byte), 32'(want.out_byte));
               check_field("block_type", 32'(rsp_block_type), 32'(want.block_type));
               check_field("last_block", 32'(rsp_last_block), 32'(want.last_block));
               check_field("field_done", 32'(rsp_field_done), 32'(want.field_done));
               check_field("field_number", rsp_field_number, want.field_number);
               check_field("block_done", 32'(rsp_block_done), 32'(want.block_done));
            end
            checked_count++;
         end
         // offer the next word, or hold the current one until taken
         if (!req_valid || req_ready) begin
            if (next_idx < feed_q.size() && $urandom_range(99) >= send_pct) begin
               req_valid <= 1'b1;
               req_data_byte <= feed_q[next_idx].data;
               req_stream_start <= feed_q[next_idx].start;
               next_idx++;
            end else begin
               req_valid <= 1'b0;
            end
         end
         rsp_ready <= !stall_hold && ($urandom_range(99) >= recv_pct);
      end
   end

   // Hold off the result side for a long stretch while words keep coming
   initial begin
      while (fed_count < (2 * feed_q.size()) / 3 + 40) @(posedge clock);
      stall_hold <= 1'b1;
      repeat (STALL_CYCLES) @(posedge clock);
      stall_hold <= 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("Timed out after %0d cycles with %0d tags outstanding",
                  cycle_count, tag_queue.size());
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin
      foreach (dir_rows[i]) feed_q.push_back(dir_rows[i]);
      while (feed_q.size() < $size(dir_rows) + RANDOM_WORDS)
         build_stream();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      while (fed_count < feed_q.size() || tag_queue.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Checked %0d tagged words from %0d files; %0d of 21 roles seen.",
               checked_count, stream_count + 3, $countones(role_seen));
      $display("Ran sender-idle, receiver-idle and back-to-back phases plus one long stall.");
      if (err_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

@@ filelist.f @@
design/fmsp_pkg.sv
design/fmsp_step.sv
design/flac_metadata_stream_parser_core.sv
tb/sv/tb_flac_metadata_stream_parser_core.sv
